### design/temp_spike_reject_ema_classifier_unit_defines.svh
// Assertion macros shared by the checker of the temperature filter.
`ifndef TEMP_SPIKE_REJECT_EMA_CLASSIFIER_UNIT_DEFINES_SVH
`define TEMP_SPIKE_REJECT_EMA_CLASSIFIER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define TSREC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication from a condition to a property in the next cycle.
`define TSREC_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### design/tsrec_pkg.sv
// Package with the shared types and constants of the temperature filter.
`timescale 1ns / 1ps

package tsrec_pkg;

	localparam int RAW_W    = 12;
	localparam int CAL_W    = 10;
	localparam int SPIKE_W  = 12;
	localparam int ALPHA_W  = 9;
	localparam int ALPHA_FRAC = 8;
	localparam int TEMP_W   = 13;
	localparam int THR_W    = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_OFFSET = 3'd0,
		CFG_MAX_SPIKE  = 3'd1,
		CFG_EMA_ALPHA  = 3'd2,
		CFG_CRIT_LOW   = 3'd3,
		CFG_CRIT_HIGH  = 3'd4,
		CFG_WARN_LOW   = 3'd5,
		CFG_WARN_HIGH  = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		LVL_OPTIMAL   = 3'd0,
		LVL_WARN_LOW  = 3'd1,
		LVL_WARN_HIGH = 3'd2,
		LVL_CRIT_LOW  = 3'd3,
		LVL_CRIT_HIGH = 3'd4
	} level_t;

	typedef struct packed {
		logic signed [CAL_W-1:0] cal_offset;
		logic [SPIKE_W-1:0]      max_spike;
		logic [ALPHA_W-1:0]      ema_alpha;
	} flt_cfg_t;

	typedef struct packed {
		logic signed [THR_W-1:0] crit_low;
		logic signed [THR_W-1:0] crit_high;
		logic signed [THR_W-1:0] warn_low;
		logic signed [THR_W-1:0] warn_high;
	} cls_thr_t;

	typedef struct packed {
		logic filter_valid;
		logic spike;
		logic lost;
	} flt_flags_t;

endpackage

### design/tsrec_filter.sv
// Spike check and moving-average update with the filter state registers.
`timescale 1ns / 1ps

module tsrec_filter
	import tsrec_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic signed [RAW_W-1:0]      raw_temp,
	input  logic                         sensor_lost,
	input  flt_cfg_t                     cfg,
	output logic signed [THR_W+FRAC_BITS-1:0] acc_next,
	output flt_flags_t                   flags_next
);

	localparam int ACC_W  = THR_W + FRAC_BITS;
	localparam int PROD_W = ACC_W + 1 + ALPHA_W + 1;
	localparam logic signed [PROD_W-1:0] ACC_MAX = PROD_W'(4095 * (1 << FRAC_BITS));
	localparam logic signed [PROD_W-1:0] ACC_MIN = -PROD_W'(4096 * (1 << FRAC_BITS));

	logic signed [ACC_W-1:0] filter_acc_q;
	logic                    filter_valid_q;
	logic signed [TEMP_W-1:0] last_raw_q;
	logic                    last_raw_valid_q;

	logic signed [TEMP_W-1:0] x;
	logic signed [TEMP_W:0]   diff;
	logic [TEMP_W:0]          abs_diff;
	logic                     spike;
	logic signed [ACC_W-1:0]  x_scaled;
	logic signed [ACC_W:0]    delta;
	logic signed [PROD_W-1:0] delta_ext;
	logic signed [PROD_W-1:0] alpha_ext;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] sum;
	logic signed [ACC_W-1:0]  ema_acc;
	logic                     accept_raw;

	always_comb begin
		x = $signed({raw_temp[RAW_W-1], raw_temp})
			+ $signed({{(TEMP_W-CAL_W){cfg.cal_offset[CAL_W-1]}}, cfg.cal_offset});
		diff = $signed({x[TEMP_W-1], x}) - $signed({last_raw_q[TEMP_W-1], last_raw_q});
		abs_diff = diff[TEMP_W] ? $unsigned(-diff) : $unsigned(diff);
		spike = last_raw_valid_q && (abs_diff > {{(TEMP_W+1-SPIKE_W){1'b0}}, cfg.max_spike});
		accept_raw = !sensor_lost && !spike;

		x_scaled = {x, {FRAC_BITS{1'b0}}};
		delta = $signed({x_scaled[ACC_W-1], x_scaled})
			- $signed({filter_acc_q[ACC_W-1], filter_acc_q});
		delta_ext = {{(PROD_W-ACC_W-1){delta[ACC_W]}}, delta};
		alpha_ext = {{(PROD_W-ALPHA_W){1'b0}}, cfg.ema_alpha};
		prod = delta_ext * alpha_ext;
		// Arithmetic shift floors toward minus infinity.
		sum = (prod >>> ALPHA_FRAC)
			+ $signed({{(PROD_W-ACC_W){filter_acc_q[ACC_W-1]}}, filter_acc_q});
		if (sum > ACC_MAX) begin
			ema_acc = ACC_MAX[ACC_W-1:0];
		end else if (sum < ACC_MIN) begin
			ema_acc = ACC_MIN[ACC_W-1:0];
		end else begin
			ema_acc = sum[ACC_W-1:0];
		end

		acc_next = filter_acc_q;
		flags_next.filter_valid = filter_valid_q;
		flags_next.spike = !sensor_lost && spike;
		flags_next.lost = sensor_lost;
		if (sensor_lost) begin
			flags_next.filter_valid = 1'b0;
		end else if (accept_raw) begin
			acc_next = filter_valid_q ? ema_acc : x_scaled;
			flags_next.filter_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_acc_q     <= '0;
			filter_valid_q   <= 1'b0;
			last_raw_q       <= '0;
			last_raw_valid_q <= 1'b0;
		end else if (advance) begin
			filter_acc_q   <= acc_next;
			filter_valid_q <= flags_next.filter_valid;
			if (accept_raw) begin
				last_raw_q       <= x;
				last_raw_valid_q <= 1'b1;
			end
		end
	end

endmodule

### design/tsrec_classify.sv
// Rounding of the filter value and threshold classification.
`timescale 1ns / 1ps

module tsrec_classify
	import tsrec_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic signed [THR_W+FRAC_BITS-1:0] acc,
	input  logic                              filter_valid,
	input  cls_thr_t                          thr,
	output logic signed [TEMP_W-1:0]          temp_out,
	output level_t                            level
);

	localparam int ACC_W = THR_W + FRAC_BITS;
	localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);

	logic signed [ACC_W:0]   rounded;
	logic signed [ACC_W-1:0] crit_low_s;
	logic signed [ACC_W-1:0] crit_high_s;
	logic signed [ACC_W-1:0] warn_low_s;
	logic signed [ACC_W-1:0] warn_high_s;

	always_comb begin
		rounded = ($signed({acc[ACC_W-1], acc}) + HALF) >>> FRAC_BITS;
		crit_low_s  = {thr.crit_low,  {FRAC_BITS{1'b0}}};
		crit_high_s = {thr.crit_high, {FRAC_BITS{1'b0}}};
		warn_low_s  = {thr.warn_low,  {FRAC_BITS{1'b0}}};
		warn_high_s = {thr.warn_high, {FRAC_BITS{1'b0}}};

		temp_out = '0;
		level = LVL_OPTIMAL;
		if (filter_valid) begin
			temp_out = rounded[TEMP_W-1:0];
			if (acc <= crit_low_s) begin
				level = LVL_CRIT_LOW;
			end else if (acc >= crit_high_s) begin
				level = LVL_CRIT_HIGH;
			end else if (acc < warn_low_s) begin
				level = LVL_WARN_LOW;
			end else if (acc > warn_high_s) begin
				level = LVL_WARN_HIGH;
			end
		end
	end

endmodule

### design/temp_spike_reject_ema_classifier_unit.sv
// Top level of the temperature filter with spike rejection and classification.
`timescale 1ns / 1ps
// A result passes through the input register, the stage 2 filter register and the output register.
// One item per cycle while the output is not stalled; each stage advances when it is empty or its content moves on.
// The filter state is updated by one multiply, an add and a clamp.
// Reset clears all stage valid bits and the filter state and loads the register defaults.

module temp_spike_reject_ema_classifier_unit
	import tsrec_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [RAW_W-1:0]  raw_temp,
	input  logic                     sensor_lost,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TEMP_W-1:0] temp_out,
	output logic                     temp_valid,
	output logic [2:0]               level,
	output logic                     spike_rejected,
	output logic                     lost_flag,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int ACC_W = THR_W + FRAC_BITS;

	// Configuration registers. Writes must arrive only while the block is idle; the block
	// itself does not enforce this, and the datapath reads them directly.
	flt_cfg_t flt_cfg_q;
	cls_thr_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flt_cfg_q.cal_offset <= '0;
			flt_cfg_q.max_spike  <= SPIKE_W'(32);
			flt_cfg_q.ema_alpha  <= ALPHA_W'(26);
			thr_q.crit_low       <= THR_W'(320);
			thr_q.crit_high      <= THR_W'(560);
			thr_q.warn_low       <= THR_W'(400);
			thr_q.warn_high      <= THR_W'(480);
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CAL_OFFSET: flt_cfg_q.cal_offset <= cfg_data[CAL_W-1:0];
				CFG_MAX_SPIKE:  flt_cfg_q.max_spike  <= cfg_data[SPIKE_W-1:0];
				CFG_EMA_ALPHA:  flt_cfg_q.ema_alpha  <= cfg_data[ALPHA_W-1:0];
				CFG_CRIT_LOW:   thr_q.crit_low       <= cfg_data[THR_W-1:0];
				CFG_CRIT_HIGH:  thr_q.crit_high      <= cfg_data[THR_W-1:0];
				CFG_WARN_LOW:   thr_q.warn_low       <= cfg_data[THR_W-1:0];
				CFG_WARN_HIGH:  thr_q.warn_high      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and the ready chain. A stage takes new data when it
	// is empty or when its content moves on in the same cycle, so the input
	// keeps flowing while a finished result waits for the downstream side.
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3 = !v_s3 || !out_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Stage 1: input register.
	logic signed [RAW_W-1:0] raw_s1;
	logic                    lost_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			raw_s1  <= raw_temp;
			lost_s1 <= sensor_lost;
		end
	end

	// Filter step. The filter state commits exactly when the stage 1 item
	// moves into stage 2, so every item sees the state left by the one before.
	logic signed [ACC_W-1:0] acc_next;
	flt_flags_t              flags_next;

	tsrec_filter #(
		.FRAC_BITS(FRAC_BITS)
	) u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (v_s1 && rdy2),
		.raw_temp   (raw_s1),
		.sensor_lost(lost_s1),
		.cfg        (flt_cfg_q),
		.acc_next   (acc_next),
		.flags_next (flags_next)
	);

	// Stage 2: filter value after this item and its flags.
	logic signed [ACC_W-1:0] acc_s2;
	flt_flags_t              flags_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			acc_s2   <= acc_next;
			flags_s2 <= flags_next;
		end
	end

	// Rounding to 1/16 degree and classification against the thresholds.
	logic signed [TEMP_W-1:0] temp_cls;
	level_t                   level_cls;

	tsrec_classify #(
		.FRAC_BITS(FRAC_BITS)
	) u_classify (
		.acc         (acc_s2),
		.filter_valid(flags_s2.filter_valid),
		.thr         (thr_q),
		.temp_out    (temp_cls),
		.level       (level_cls)
	);

	// Stage 3: output register that holds the result until its transfer.
	logic signed [TEMP_W-1:0] temp_s3;
	level_t                   level_s3;
	flt_flags_t               flags_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			temp_s3  <= temp_cls;
			level_s3 <= level_cls;
			flags_s3 <= flags_s2;
		end
	end

	assign out_valid      = v_s3;
	assign temp_out       = temp_s3;
	assign temp_valid     = flags_s3.filter_valid;
	assign level          = level_s3;
	assign spike_rejected = flags_s3.spike;
	assign lost_flag      = flags_s3.lost;

endmodule

### design/tsrec_chk.sv
// Port checker of the temperature filter and its binding to the top level.
`timescale 1ns / 1ps
`include "temp_spike_reject_ema_classifier_unit_defines.svh"

module tsrec_chk
	import tsrec_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [TEMP_W-1:0] temp_out,
	input logic                     temp_valid,
	input logic [2:0]               level,
	input logic                     spike_rejected,
	input logic                     lost_flag
);

	`TSREC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`TSREC_ASSERT(a_invalid_zero, clk, arst_n, !(out_valid && !temp_valid) || (temp_out == '0 && level == LVL_OPTIMAL), "invalid result carries data")
	`TSREC_ASSERT(a_lost_result, clk, arst_n, !(out_valid && lost_flag) || (!temp_valid && !spike_rejected), "lost sensor result inconsistent")
	`TSREC_ASSERT(a_level_range, clk, arst_n, !out_valid || (level <= LVL_CRIT_HIGH), "level code out of range")

endmodule

bind temp_spike_reject_ema_classifier_unit tsrec_chk u_tsrec_chk (.*);

### dv/tb_top.sv
// Self-checking testbench for the temperature filter with spike rejection and classification.
`timescale 1ns / 1ps

module tb_top;
	import tsrec_pkg::*;

	localparam int FRAC_BITS    = 8;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 141;
	localparam int REPORT_MAX = 10;

	// One expected result of the filter for one input transfer.
	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic                     valid;
		level_t                   lvl;
		logic                     spike;
		logic                     lost;
	} reading_result_t;

	// Tracks the filter registers and state, predicts each result and checks
	// the results in order against what the block delivers.
	class reading_tracker;
		logic signed [CAL_W-1:0]  cal;
		logic [SPIKE_W-1:0]       spike_max;
		logic [ALPHA_W-1:0]       alpha;
		logic signed [THR_W-1:0]  crit_lo, crit_hi, warn_lo, warn_hi;
		longint                   acc;
		bit                       have_filter;
		longint                   last_x;
		bit                       have_last;
		reading_result_t          expected_readings[$];
		int                       mismatches;
		int                       results_checked;
		int                       spikes_seen;
		int                       lost_seen;

		function new();
			cal = '0;
			spike_max = 12'd32;
			alpha = 9'd26;
			crit_lo = 13'sd320;
			crit_hi = 13'sd560;
			warn_lo = 13'sd400;
			warn_hi = 13'sd480;
			acc = 0;
			have_filter = 0;
			last_x = 0;
			have_last = 0;
			mismatches = 0;
			results_checked = 0;
			spikes_seen = 0;
			lost_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (cfg_idx_t'(idx))
				CFG_CAL_OFFSET: cal = data[CAL_W-1:0];
				CFG_MAX_SPIKE:  spike_max = data[SPIKE_W-1:0];
				CFG_EMA_ALPHA:  alpha = data[ALPHA_W-1:0];
				CFG_CRIT_LOW:   crit_lo = data[THR_W-1:0];
				CFG_CRIT_HIGH:  crit_hi = data[THR_W-1:0];
				CFG_WARN_LOW:   warn_lo = data[THR_W-1:0];
				CFG_WARN_HIGH:  warn_hi = data[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_reading(logic signed [RAW_W-1:0] raw, logic lost);
			longint one, x, jump, t;
			reading_result_t r;
			one = longint'(1) << FRAC_BITS;
			r.spike = 1'b0;
			r.lost = lost;
			if (lost) begin
				have_filter = 0;
			end else begin
				x = longint'(raw) + longint'(cal);
				jump = x - last_x;
				if (jump < 0)
					jump = -jump;
				if (have_last && jump > longint'(spike_max)) begin
					r.spike = 1'b1;
				end else begin
					last_x = x;
					have_last = 1;
					if (!have_filter) begin
						acc = x * one;
						have_filter = 1;
					end else begin
						acc += ((x * one - acc) * longint'(alpha)) >>> ALPHA_FRAC;
					end
					if (acc < -4096 * one)
						acc = -4096 * one;
					if (acc > 4095 * one)
						acc = 4095 * one;
				end
			end
			r.valid = have_filter;
			r.temp = '0;
			r.lvl = LVL_OPTIMAL;
			if (have_filter) begin
				t = (acc + (one >>> 1)) >>> FRAC_BITS;
				r.temp = t[TEMP_W-1:0];
				if (acc <= longint'(crit_lo) * one)
					r.lvl = LVL_CRIT_LOW;
				else if (acc >= longint'(crit_hi) * one)
					r.lvl = LVL_CRIT_HIGH;
				else if (acc < longint'(warn_lo) * one)
					r.lvl = LVL_WARN_LOW;
				else if (acc > longint'(warn_hi) * one)
					r.lvl = LVL_WARN_HIGH;
			end
			if (r.spike)
				spikes_seen++;
			if (lost)
				lost_seen++;
			expected_readings.push_back(r);
		endfunction

		function void check_reading(logic signed [TEMP_W-1:0] temp, logic valid,
				logic [2:0] lvl, logic spike, logic lost);
			reading_result_t e;
			results_checked++;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d arrived with no reading pending", results_checked);
				return;
			end
			e = expected_readings.pop_front();
			if (temp !== e.temp || valid !== e.valid || lvl !== e.lvl ||
					spike !== e.spike || lost !== e.lost) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$write("result %0d: expected temp=%0d valid=%0b level=%0d spike=%0b lost=%0b",
						results_checked, e.temp, e.valid, e.lvl, e.spike, e.lost);
					$display(", got temp=%0d valid=%0b level=%0d spike=%0b lost=%0b",
						temp, valid, lvl, spike, lost);
				end
			end
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [RAW_W-1:0]  raw_temp;
	logic                     sensor_lost;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [TEMP_W-1:0] temp_out;
	logic                     temp_valid;
	logic [2:0]               level;
	logic                     spike_rejected;
	logic                     lost_flag;
	logic                     cfg_wr_en;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	reading_tracker tracker = new();
	int unsigned cycle_count = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int out_hold = 0;
	int items_sent = 0;
	int settings_used = 1;

	temp_spike_reject_ema_classifier_unit #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_temp(raw_temp),
		.sensor_lost(sensor_lost),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temp_out(temp_out),
		.temp_valid(temp_valid),
		.level(level),
		.spike_rejected(spike_rejected),
		.lost_flag(lost_flag),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Everything is sampled at the rising edge, while the inputs are stable
	// since they only move on the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				tracker.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				tracker.note_reading(raw_temp, sensor_lost);
			if (out_valid && !out_stall)
				tracker.check_reading(temp_out, temp_valid, level, spike_rejected, lost_flag);
		end
	end

	// Most gaps are short; a few are long enough to fill the pipeline.
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver back-pressure runs on its own for the whole test.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
				out_hold = pick_gap(out_stall_pct);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Holds valid high across back-to-back transfers, so valid is only
	// lowered when a gap is wanted, and then raised on a later falling edge.
	task automatic send_reading(input logic signed [RAW_W-1:0] raw, input logic lost);
		int gap;
		gap = pick_gap(in_idle_pct);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		raw_temp <= raw;
		sensor_lost <= lost;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	// Drops valid and lets every outstanding result drain before anything
	// touches the registers.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
	endtask

	task automatic program_filter(input int cal, input int spike, input int alpha,
			input int cl, input int ch, input int wl, input int wh);
		put_reg(CFG_CAL_OFFSET, cal);
		put_reg(CFG_MAX_SPIKE, spike);
		put_reg(CFG_EMA_ALPHA, alpha);
		put_reg(CFG_CRIT_LOW, cl);
		put_reg(CFG_CRIT_HIGH, ch);
		put_reg(CFG_WARN_LOW, wl);
		put_reg(CFG_WARN_HIGH, wh);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	function automatic int pick_alpha();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 256;
		if (r == 2)
			return $urandom_range(257, 511);
		return $urandom_range(1, 255);
	endfunction

	function automatic int pick_spike();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 4095;
		if (r < 4)
			return $urandom_range(65, 4095);
		return $urandom_range(1, 64);
	endfunction

	// Thresholds are placed around the last accepted reading so that the
	// walk crosses them; sometimes they are thrown anywhere in range.
	task automatic choose_thresholds(output int cl, output int ch, output int wl, output int wh);
		int center;
		center = tracker.have_last ? int'(tracker.last_x) : 0;
		if ($urandom_range(0, 9) < 3) begin
			cl = int'($urandom_range(0, 8191)) - 4096;
			ch = int'($urandom_range(0, 8191)) - 4096;
			wl = int'($urandom_range(0, 8191)) - 4096;
			wh = int'($urandom_range(0, 8191)) - 4096;
		end else begin
			cl = center - int'($urandom_range(10, 120));
			wl = cl + int'($urandom_range(0, 80));
			ch = center + int'($urandom_range(10, 120));
			wh = ch - int'($urandom_range(0, 80));
		end
	endtask

	// Mostly a random walk that stays within the accepted jump, with some
	// jumps right at the limit and just past it, some lost readings and
	// some readings anywhere in range.
	task automatic next_reading(output logic signed [RAW_W-1:0] raw, output logic lost);
		int r, lim, span, delta, target;
		r = $urandom_range(0, 99);
		lim = int'(tracker.spike_max);
		span = (lim > 150) ? 150 : lim;
		lost = 1'b0;
		delta = 0;
		if (r < 6) begin
			lost = 1'b1;
			raw = RAW_W'($urandom_range(0, 4095));
			return;
		end
		if (r < 14) begin
			raw = RAW_W'($urandom_range(0, 4095));
			return;
		end
		if (r < 26)
			delta = lim + int'($urandom_range(0, 1));
		else
			delta = int'($urandom_range(0, 2 * span)) - span;
		if (r < 26 && $urandom_range(0, 1) == 1)
			delta = -delta;
		target = (tracker.have_last ? int'(tracker.last_x) : 0) + delta - int'(tracker.cal);
		if (target < -2048)
			target = -2048;
		if (target > 2047)
			target = 2047;
		raw = RAW_W'(target);
	endtask

	initial begin
		logic signed [RAW_W-1:0] raw;
		logic lost;
		int cal, spike, alpha, cl, ch, wl, wh;

		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_temp = '0;
		sensor_lost = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_CAL_OFFSET;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults: loss before any reading, first load, spikes at
		// both ends of the input range, a jump exactly at the limit and one
		// past it, and a spike while the filter is still invalid after loss.
		in_idle_pct = 20;
		out_stall_pct = 20;
		send_reading(12'sd2047, 1'b1);
		send_reading(12'sd450, 1'b0);
		send_reading(12'sd2047, 1'b0);
		send_reading(-12'sd2048, 1'b0);
		send_reading(12'sd482, 1'b0);
		send_reading(12'sd515, 1'b0);
		send_reading(-12'sd1, 1'b1);
		send_reading(12'sd2047, 1'b0);
		send_reading(12'sd470, 1'b0);
		send_reading(12'sd400, 1'b0);
		settle();

		// No smoothing and no spike limit, so each reading lands on the
		// output directly and every threshold edge can be hit exactly.
		program_filter(0, 4095, 256, 320, 560, 400, 480);
		send_reading(12'sd320, 1'b0);
		send_reading(12'sd321, 1'b0);
		send_reading(12'sd399, 1'b0);
		send_reading(12'sd400, 1'b0);
		send_reading(12'sd480, 1'b0);
		send_reading(12'sd481, 1'b0);
		send_reading(12'sd559, 1'b0);
		send_reading(12'sd560, 1'b0);
		send_reading(-12'sd2048, 1'b0);
		send_reading(12'sd2047, 1'b0);
		send_reading(-12'sd1, 1'b0);
		send_reading(12'sd0, 1'b0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			choose_thresholds(cl, ch, wl, wh);
			cal = int'($urandom_range(0, 1023)) - 512;
			spike = pick_spike();
			alpha = pick_alpha();
			case (p)
				0: program_filter(0, 4095, 256, cl, ch, wl, wh);
				1: program_filter(-512, 0, 1, -4096, 4095, -4096, 4095);
				2: program_filter(511, $urandom_range(1, 64), 0, cl, ch, wl, wh);
				// Overshooting steps with no spike limit drive the clamp.
				3: program_filter(cal, 4095, 511, cl, ch, wl, wh);
				4: program_filter(cal, spike, alpha, 4095, -4096, 0, 0);
				default: program_filter(cal, spike, alpha, cl, ch, wl, wh);
			endcase
			case (p % 4)
				0: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct = 30;
					out_stall_pct = 30;
				end
				2: begin
					in_idle_pct = 10;
					out_stall_pct = 50;
				end
				default: begin
					in_idle_pct = 50;
					out_stall_pct = 10;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				next_reading(raw, lost);
				send_reading(raw, lost);
			end
			settle();
		end

		$display("Sent %0d readings under %0d register settings; %0d results checked.",
			items_sent, settings_used, tracker.results_checked);
		$display("Readings rejected as spikes: %0d, lost-sensor readings: %0d, mismatches: %0d.",
			tracker.spikes_seen, tracker.lost_seen, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
